/* rtl/core/lpfd_pkg.sv */
// lpfd_pkg: shared types for the length-prefixed frame decoder
// result item layout passed from the header/payload parser to the output register
`timescale 1ns / 1ps

package lpfd_pkg;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic        last_of_frame;
    logic [31:0] frame_number;
    logic        bad_length;
  } result_t;

endpackage

/* rtl/core/lpfd_parse.sv */
// lpfd_parse: header assembly, payload countdown and result formation
// holds the frame state; uses lpfd_pkg for the result struct
`timescale 1ns / 1ps

module lpfd_parse
  import lpfd_pkg::*;
#(
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    action,
  input  logic [7:0] rx_byte,
  output logic    res_valid,
  output result_t res
);

  localparam int HdrBytes = LENGTH_FIELD_BYTES + 4;
  localparam int LenW     = 8 * LENGTH_FIELD_BYTES;
  localparam int HcW      = $clog2(HdrBytes + 1);

  logic [HcW-1:0]  header_count, header_count_next, hc_inc;
  logic [LenW-1:0] frame_length, frame_length_next, len_base;
  logic [31:0]     current_number, current_number_next, num_base;
  logic [LenW-1:0] bytes_remaining, bytes_remaining_next;

  always_comb begin
    header_count_next    = header_count;
    frame_length_next    = frame_length;
    current_number_next  = current_number;
    bytes_remaining_next = bytes_remaining;
    res_valid            = 1'b0;
    res                  = '0;
    len_base             = (header_count == '0) ? '0 : frame_length;
    num_base             = (header_count == '0) ? '0 : current_number;
    hc_inc               = header_count + HcW'(1);
    if (action) begin
      header_count_next    = '0;
      bytes_remaining_next = '0;
    end else if (bytes_remaining != '0) begin
      bytes_remaining_next = bytes_remaining - LenW'(1);
      res_valid            = 1'b1;
      res.payload_byte     = rx_byte;
      res.has_payload      = 1'b1;
      res.last_of_frame    = (bytes_remaining == LenW'(1));
      res.frame_number     = current_number;
    end else begin
      frame_length_next   = len_base;
      current_number_next = num_base;
      if (header_count < HcW'(LENGTH_FIELD_BYTES)) begin
        frame_length_next = {len_base[LenW-9:0], rx_byte};
      end else begin
        current_number_next = {num_base[23:0], rx_byte};
      end
      header_count_next = hc_inc;
      if (hc_inc == HcW'(HdrBytes)) begin
        header_count_next = '0;
        if (frame_length_next <= LenW'(HdrBytes)) begin
          res_valid          = 1'b1;
          res.last_of_frame  = 1'b1;
          res.frame_number   = current_number_next;
          res.bad_length     = (frame_length_next < LenW'(HdrBytes));
        end else begin
          bytes_remaining_next = frame_length_next - LenW'(HdrBytes);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      frame_length    <= '0;
      current_number  <= '0;
      bytes_remaining <= '0;
    end else if (step) begin
      header_count    <= header_count_next;
      frame_length    <= frame_length_next;
      current_number  <= current_number_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

/* rtl/core/lpfd_outreg.sv */
// lpfd_outreg: result register with valid/stall handshake toward the sink
// uses lpfd_pkg for the result struct
`timescale 1ns / 1ps

module lpfd_outreg
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        has_payload,
  output logic        last_of_frame,
  output logic [31:0] frame_number,
  output logic        bad_length
);

  result_t held;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign payload_byte  = held.payload_byte;
  assign has_payload   = held.has_payload;
  assign last_of_frame = held.last_of_frame;
  assign frame_number  = held.frame_number;
  assign bad_length    = held.bad_length;

endmodule

/* rtl/core/length_prefixed_frame_decoder_top.sv */
// length_prefixed_frame_decoder_top: input register, parser and result register
// depends on lpfd_pkg, lpfd_parse, lpfd_outreg
//
//   channel | handshake           | fields
//   --------+---------------------+----------------------------------------------
//   input   | in_valid / in_stall | action, rx_byte
//   output  | out_valid/out_stall | payload_byte, has_payload, last_of_frame,
//           |                     | frame_number, bad_length
//
// one item per cycle sustained while the output is not stalled; the input
// register takes the item when it is accepted and the result register loads
// its result when the parser steps, and the result register drives the output
// synchronous active-high reset clears frame state and both valid flags
// a stalled output holds its result; the input register keeps accepting
// while the result register is free or being taken in the same cycle
`timescale 1ns / 1ps

module length_prefixed_frame_decoder_top
  import lpfd_pkg::*;
#(
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        has_payload,
  output logic        last_of_frame,
  output logic [31:0] frame_number,
  output logic        bad_length
);

  logic       s1_valid;
  logic       s1_action;
  logic [7:0] s1_byte;
  logic       ready;
  logic       step;
  logic       accept;
  logic       res_valid;
  result_t    res;

  assign step     = s1_valid && ready;
  assign in_stall = s1_valid && !ready;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_byte   <= rx_byte;
    end
  end

  lpfd_parse #(
    .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .action   (s1_action),
    .rx_byte  (s1_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  lpfd_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .load         (step && res_valid),
    .res          (res),
    .ready        (ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .has_payload  (has_payload),
    .last_of_frame(last_of_frame),
    .frame_number (frame_number),
    .bad_length   (bad_length)
  );

endmodule
